/* rtl/symtab_pkg.sv */
// ----------------------------------------------------------------------------
// symtab_pkg
// Shared constants, codes and control structs of the symbol table block.
// ----------------------------------------------------------------------------
package symtab_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int KEY_BITS    = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 16;
    localparam int CELLS_W     = 16;
    localparam int ATTR_W      = CELLS_W + 2 + ADDR_W;
    localparam int STATUS_W    = 2;

    // request kinds
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd3;

    // result index source
    localparam logic [1:0] SEL_ZERO  = 2'd0;
    localparam logic [1:0] SEL_HIT   = 2'd1;
    localparam logic [1:0] SEL_COUNT = 2'd2;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [ATTR_W-1:0]   attr_t;

    // controller to datapath
    typedef struct packed {
        logic                load;
        logic                start;
        logic                scan;
        logic                write;
        logic                finish;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          res_sel;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_insert;
        logic full;
        logic empty;
        logic hit;
        logic miss;
    } dp_sts_t;

endpackage

/* rtl/symtab_dpath.sv */
// ----------------------------------------------------------------------------
// symtab_dpath
// Request latch, key and attribute memories, scan pointer, key compare,
// fill count and result register.
// ----------------------------------------------------------------------------
module symtab_dpath
    import symtab_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    input  logic                req_type,
    input  logic [63:0]         key,
    input  logic [ADDR_W-1:0]   mem_address,
    input  logic                value_kind,
    input  logic                category,
    input  logic [CELLS_W-1:0]  cell_count,
    output logic [STATUS_W-1:0] status,
    output logic [IDX_W-1:0]    index
);

    key_t                key_mem [TABLE_DEPTH];
    attr_t               attr_mem [TABLE_DEPTH];

    logic                req_type_reg;
    key_t                key_reg;
    attr_t               attr_reg;
    logic [CNT_W-1:0]    used_count_reg;
    logic [IDX_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                cmp_vld_reg;
    key_t                rd_key_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [IDX_W-1:0]    index_reg;
    logic [IDX_W-1:0]    index_next;
    logic                match;

    // request latch, key kept at full width
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req_type;
            key_reg      <= key[KEY_BITS-1:0];
            attr_reg     <= {cell_count, category, value_kind, mem_address};
        end
    end

    // key and attribute memories, one write and one key read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            key_mem[used_count_reg[IDX_W-1:0]]  <= key_reg;
            attr_mem[used_count_reg[IDX_W-1:0]] <= attr_reg;
        end
        if (cmd.scan)
        begin
            rd_key_reg <= key_mem[ptr_reg];
        end
    end

    // scan pointer walks from newest entry down to index zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            cmp_idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            ptr_reg     <= IDX_W'(used_count_reg - CNT_W'(1));
            cmp_vld_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_idx_reg <= ptr_reg;
            cmp_vld_reg <= 1'b1;
            if (ptr_reg != '0)
            begin
                ptr_reg <= ptr_reg - IDX_W'(1);
            end
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
        end
        else if (cmd.write)
        begin
            used_count_reg <= used_count_reg + CNT_W'(1);
        end
    end

    // result index select
    always_comb
    begin
        unique case (cmd.res_sel)
            SEL_HIT:   index_next = cmp_idx_reg;
            SEL_COUNT: index_next = used_count_reg[IDX_W-1:0];
            default:   index_next = '0;
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= cmd.res_status;
            index_reg  <= index_next;
        end
    end

    // compare and status toward the controller
    assign match         = (rd_key_reg == key_reg);
    assign sts.is_insert = (req_type_reg == REQ_INSERT);
    assign sts.full      = (used_count_reg == CNT_W'(TABLE_DEPTH));
    assign sts.empty     = (used_count_reg == '0);
    assign sts.hit       = cmp_vld_reg && match;
    assign sts.miss      = cmp_vld_reg && !match && (cmp_idx_reg == '0);

    assign status = status_reg;
    assign index  = index_reg;

endmodule

/* rtl/symtab_ctrl.sv */
// ----------------------------------------------------------------------------
// symtab_ctrl
// Sequencer for one request at a time: latch, table checks, key scan,
// append and result hand-off.
// ----------------------------------------------------------------------------
module symtab_ctrl
    import symtab_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_status = ST_OK;
        cmd.res_sel    = SEL_ZERO;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (sts.is_insert && sts.full)
                begin
                    if (out_free)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.res_status = ST_FULL;
                        state_next     = S_IDLE;
                    end
                end
                else if (sts.empty)
                begin
                    if (out_free)
                    begin
                        cmd.finish = 1'b1;
                        if (sts.is_insert)
                        begin
                            cmd.write   = 1'b1;
                            cmd.res_sel = SEL_COUNT;
                        end
                        else
                        begin
                            cmd.res_status = ST_NOT_FOUND;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (sts.hit)
                begin
                    if (out_free)
                    begin
                        cmd.finish = 1'b1;
                        if (sts.is_insert)
                        begin
                            cmd.res_status = ST_DUPLICATE;
                        end
                        else
                        begin
                            cmd.res_sel = SEL_HIT;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (sts.miss)
                begin
                    if (out_free)
                    begin
                        cmd.finish = 1'b1;
                        if (sts.is_insert)
                        begin
                            cmd.write   = 1'b1;
                            cmd.res_sel = SEL_COUNT;
                        end
                        else
                        begin
                            cmd.res_status = ST_NOT_FOUND;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/symbol_table_insert_lookup.sv */
// ----------------------------------------------------------------------------
// symbol_table_insert_lookup
// Append-only symbol table with newest-first linear key search.
// ----------------------------------------------------------------------------
// One item is handled at a time. A lookup, or an insert that is not refused as
// full, scans the stored keys from the newest entry down to index zero, one
// key per cycle through the single read port of the key memory, and stops at
// the first match. The result is settled straight from the table checks when
// the table is empty or an insert finds it full, and no scan is then made.
// A finished result waits in the output register while the next item is
// taken in. No clearing pass follows reset: entries are read only once
// written.
module symbol_table_insert_lookup
    import symtab_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [63:0]         key,
    input  logic [ADDR_W-1:0]   mem_address,
    input  logic                value_kind,
    input  logic                category,
    input  logic [CELLS_W-1:0]  cell_count,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [IDX_W-1:0]    index
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // sequencer
    symtab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    // table storage and search datapath
    symtab_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .sts         (dp_sts),
        .req_type    (req_type),
        .key         (key),
        .mem_address (mem_address),
        .value_kind  (value_kind),
        .category    (category),
        .cell_count  (cell_count),
        .status      (status),
        .index       (index)
    );

    // one item in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new item accepted while one is in work");

    // refused or missed results carry index zero
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (index == '0))
        else $error("nonzero index on a refused or missed result");

    // full status only while the table is really full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> dp_sts.full)
        else $error("full status reported with room left");

    // never append past the table limit
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.write |-> !dp_sts.full)
        else $error("append into a full table");

endmodule

/* tb/symtab_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symtab_checker
// Watches the request and result channels of the symbol table, keeps its own
// copy of the table to predict every result, and compares results in order.
// ----------------------------------------------------------------------------
module symtab_checker
    import symtab_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                req_type,
    input  logic [63:0]         key,
    input  logic [ADDR_W-1:0]   mem_address,
    input  logic                value_kind,
    input  logic                category,
    input  logic [CELLS_W-1:0]  cell_count,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [IDX_W-1:0]    index,
    output int                  mismatches,
    output int                  pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
    } table_result_t;

    // shadow copy of the table
    key_t          table_keys  [TABLE_DEPTH];
    attr_t         table_attrs [TABLE_DEPTH];
    int            entries_used;
    table_result_t predicted_results[$];

    // newest stored entry holding the key, or -1
    function automatic int find_newest(input key_t k);
        for (int i = entries_used - 1; i >= 0; i--)
        begin
            if (table_keys[i] == k)
                return i;
        end
        return -1;
    endfunction

    // updates the shadow table and returns the result the block owes
    function automatic table_result_t apply_request(input logic rt, input key_t k,
                                                    input attr_t attrs);
        table_result_t r;
        int            hit;
        r.status = ST_OK;
        r.index  = '0;
        if (rt == REQ_LOOKUP)
        begin
            hit = find_newest(k);
            if (hit < 0)
                r.status = ST_NOT_FOUND;
            else
                r.index = IDX_W'(hit);
        end
        // full check wins over the duplicate check
        else if (entries_used >= TABLE_DEPTH)
            r.status = ST_FULL;
        else if (find_newest(k) >= 0)
            r.status = ST_DUPLICATE;
        else
        begin
            table_keys[entries_used]  = k;
            table_attrs[entries_used] = attrs;
            r.index = IDX_W'(entries_used);
            entries_used++;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        if (!rst_n)
        begin
            entries_used = 0;
            predicted_results.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            // compare a delivered result with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("unexpected result: status %0d index %0d", status, index);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (status !== want.status || index !== want.index)
                        mismatches <= mismatches + 1;
                    if (status !== want.status)
                        $error("status: expected %0d, got %0d", want.status, status);
                    if (index !== want.index)
                        $error("index: expected %0d, got %0d", want.index, index);
                end
            end
            // predict the result of an accepted item
            if (in_valid && in_ready)
                predicted_results.push_back(apply_request(req_type, key[KEY_BITS-1:0],
                    {cell_count, category, value_kind, mem_address}));
            pending <= predicted_results.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives lookups and inserts into the symbol table: a directed opening on
// key and attribute extremes, then random traffic that fills the table and
// keeps probing it once full, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import symtab_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 140;
    localparam int RANDOM_ITEMS = 1730;
    localparam int STEADY_ITEMS = 200;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                req_type    = REQ_LOOKUP;
    logic [63:0]         key         = '0;
    logic [ADDR_W-1:0]   mem_address = '0;
    logic                value_kind  = 1'b0;
    logic                category    = 1'b0;
    logic [CELLS_W-1:0]  cell_count  = '0;
    logic                out_ready   = 1'b0;
    logic                in_ready;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    index;

    logic        idling      = 1'b1;
    int          stall_left  = 0;
    int          quiet_cycles = 0;
    int          mismatches;
    int          pending;
    logic [63:0] sent_keys[$];

    always #1 clk = ~clk;

    symbol_table_insert_lookup DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .key         (key),
        .mem_address (mem_address),
        .value_kind  (value_kind),
        .category    (category),
        .cell_count  (cell_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .index       (index)
    );

    symtab_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .key         (key),
        .mem_address (mem_address),
        .value_kind  (value_kind),
        .category    (category),
        .cell_count  (cell_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .index       (index),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // result side back-pressure in random bursts
    always @(posedge clk)
    begin
        if (!rst_n || !idling)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_ready <= 1'b1;
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** symbol_table_insert_lookup: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // presents one item and returns at the edge where it is accepted
    task automatic issue_request(input logic rt, input logic [63:0] k,
                                 input logic [ADDR_W-1:0] addr, input logic vk,
                                 input logic cat, input logic [CELLS_W-1:0] cells);
        int gap;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= rt;
        key         <= k;
        mem_address <= addr;
        value_kind  <= vk;
        category    <= cat;
        cell_count  <= cells;
        if (rt == REQ_INSERT)
            sent_keys.push_back(k);
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    // item with random attributes
    task automatic issue_random_attrs(input logic rt, input logic [63:0] k);
        issue_request(rt, k, ADDR_W'($urandom), 1'($urandom), 1'($urandom),
                      CELLS_W'($urandom));
    endtask

    function automatic logic [63:0] random_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pool_key();
        return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    endfunction

    initial
    begin
        int          pick;
        logic [63:0] k;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: lookups miss
        issue_request(REQ_LOOKUP, 64'h0, '0, 1'b0, 1'b0, '0);
        issue_request(REQ_LOOKUP, '1, '1, 1'b1, 1'b1, '1);
        // first inserts with attribute extremes
        issue_request(REQ_INSERT, 64'h0, '0, 1'b0, 1'b0, '0);
        issue_request(REQ_INSERT, '1, '1, 1'b1, 1'b1, '1);
        // same keys again are refused as duplicates
        issue_request(REQ_INSERT, 64'h0, '1, 1'b1, 1'b1, '1);
        issue_request(REQ_INSERT, '1, '0, 1'b0, 1'b0, '0);
        // lookups ignore the attribute fields
        issue_request(REQ_LOOKUP, 64'h0, '1, 1'b1, 1'b1, '1);
        issue_request(REQ_LOOKUP, '1, '0, 1'b0, 1'b0, '0);
        // single-bit neighbors of stored keys and alternating bit patterns
        issue_request(REQ_LOOKUP, 64'h1, 16'h5555, 1'b0, 1'b1, 16'hAAAA);
        issue_request(REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b1, 1'b0, '1);
        issue_request(REQ_INSERT, 64'h8000_0000_0000_0000, 16'h8000, 1'b1, 1'b0, 16'h0001);
        issue_request(REQ_INSERT, 64'h1, 16'h0001, 1'b0, 1'b1, 16'h8000);
        issue_request(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA, 1'b1, 1'b1, 16'h5555);
        issue_request(REQ_INSERT, 64'h5555_5555_5555_5555, 16'h5555, 1'b0, 1'b0, 16'hAAAA);
        issue_request(REQ_LOOKUP, 64'h8000_0000_0000_0000, '0, 1'b0, 1'b0, '0);
        issue_request(REQ_LOOKUP, 64'h1, '0, 1'b0, 1'b0, '0);
        issue_request(REQ_LOOKUP, 64'h5555_5555_5555_5555, '1, 1'b1, 1'b1, '1);
        issue_request(REQ_LOOKUP, 64'h0, '0, 1'b0, 1'b0, '0);
        issue_request(REQ_INSERT, 64'h5555_5555_5555_5555, '0, 1'b0, 1'b0, '0);
        issue_request(REQ_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAB, '0, 1'b0, 1'b0, '0);

        // random traffic: fills the table, then keeps probing it when full
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= RANDOM_ITEMS - STEADY_ITEMS)
                idling <= 1'b0;
            else if (n % 64 == 0)
                idling <= ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 34)
                k = random_key();
            else if (pick < 75)
                k = pool_key();
            else if (pick < 88)
                k = pool_key() ^ (64'h1 << $urandom_range(0, 63));
            else
                k = random_key();
            issue_random_attrs((pick < 45) ? REQ_INSERT : REQ_LOOKUP, k);
        end
        in_valid <= 1'b0;

        // drain outstanding results
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("** symbol_table_insert_lookup: PASSED **");
        else
            $display("** symbol_table_insert_lookup: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/symtab_pkg.sv
rtl/symtab_dpath.sv
rtl/symtab_ctrl.sv
rtl/symbol_table_insert_lookup.sv
tb/symtab_checker.sv
tb/testbench.sv
